### sv/ordered_list_engine_unit_defines.svh
// Assertion macros used by the port checker of the ordered list engine
`ifndef ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OLEU_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication, disabled during reset
`define OLEU_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

### sv/olist_pkg.sv
// Package: types, codes and widths of the ordered list engine
`timescale 1ns / 1ps

package olist_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int SLOT_MAX_W   = 11;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 6;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND  = 3'd0,
    FN_PREPEND = 3'd1,
    FN_INSERT  = 3'd2,
    FN_REMOVE  = 3'd3,
    FN_FIND    = 3'd4,
    FN_READ    = 3'd5,
    FN_CLEAR   = 3'd6
  } olist_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_POS   = 2'd3
  } olist_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_SCAN,
    S_PLACE,
    S_FIX,
    S_UNLINK,
    S_DONE
  } olist_state_e;

  typedef struct packed {
    logic [SLOT_MAX_W-1:0] rd_addr;
    logic                  val_we;
    logic [SLOT_MAX_W-1:0] val_addr;
    logic [VALUE_W-1:0]    val_wdata;
    logic                  lnk_we;
    logic [SLOT_MAX_W-1:0] lnk_addr;
    logic [SLOT_MAX_W-1:0] lnk_wdata;
  } olist_mem_req_t;

endpackage

### sv/ordered_list_engine_unit.sv
// Clear and rejected operations go straight to the result; the longest operation is an
// insert walking the whole chain, then scanning the used map for a free slot.
// Throughput: one item at a time; the chain is walked one slot per cycle through
// the read port of the slot memories, and the free-slot scan takes one slot per cycle.
// Reset: list empty, used map cleared; slot memories are not cleared.
`timescale 1ns / 1ps

module ordered_list_engine_unit import olist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // value[31:0], position[37:32]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // func[2:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // data[31:0], length[37:32]
  output logic [OUT_USER_W-1:0] m_axis_tuser    // status[1:0], found[2]
);

  olist_mem_req_t        mem_req;
  logic [VALUE_W-1:0]    val_rdata;
  logic [SLOT_MAX_W-1:0] lnk_rdata;
  logic [STATUS_W-1:0]   status;
  logic                  found;
  logic [VALUE_W-1:0]    data;
  logic [LEN_W-1:0]      length;

  olist_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser[FUNC_W-1:0]),
    .value_i    (s_axis_tdata[VALUE_W-1:0]),
    .pos_i      (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_o   (status),
    .found_o    (found),
    .data_o     (data),
    .length_o   (length),
    .mem_req_o  (mem_req),
    .val_rdata_i(val_rdata),
    .lnk_rdata_i(lnk_rdata)
  );

  olist_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .val_rdata_o(val_rdata),
    .lnk_rdata_o(lnk_rdata)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - VALUE_W - LEN_W){1'b0}}, length, data};
  assign m_axis_tuser = {found, status};

endmodule

### sv/olist_store.sv
// Slot store: value and link memories, one write and one registered read each
`timescale 1ns / 1ps

module olist_store import olist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  olist_mem_req_t        req_i,
  output logic [VALUE_W-1:0]    val_rdata_o,
  output logic [SLOT_MAX_W-1:0] lnk_rdata_o
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int SLOT_W = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] val_mem [CAPACITY];
  logic [SLOT_W-1:0]  lnk_mem [CAPACITY];
  logic [VALUE_W-1:0] val_rdata_q;
  logic [SLOT_W-1:0]  lnk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.val_we) begin
      val_mem[req_i.val_addr[ADDR_W-1:0]] <= req_i.val_wdata;
    end
    if (req_i.lnk_we) begin
      lnk_mem[req_i.lnk_addr[ADDR_W-1:0]] <= req_i.lnk_wdata[SLOT_W-1:0];
    end
    val_rdata_q <= val_mem[req_i.rd_addr[ADDR_W-1:0]];
    lnk_rdata_q <= lnk_mem[req_i.rd_addr[ADDR_W-1:0]];
  end

  assign val_rdata_o = val_rdata_q;
  assign lnk_rdata_o = SLOT_MAX_W'(lnk_rdata_q);

endmodule

### sv/olist_ctrl.sv
// Sequencer: chain walk, free-slot scan, link updates and result register
`timescale 1ns / 1ps

module olist_ctrl import olist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic [POS_W-1:0]      pos_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  found_o,
  output logic [VALUE_W-1:0]    data_o,
  output logic [LEN_W-1:0]      length_o,
  output olist_mem_req_t        mem_req_o,
  input  logic [VALUE_W-1:0]    val_rdata_i,
  input  logic [SLOT_MAX_W-1:0] lnk_rdata_i
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int CNT_W  = SLOT_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);

  olist_state_e        state_q, state_d;
  olist_func_e         func_q, func_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [SLOT_W-1:0]   cur_q, cur_d;
  logic [SLOT_W-1:0]   prev_q, prev_d;
  logic [SLOT_W-1:0]   succ_q, succ_d;
  logic [SLOT_W-1:0]   new_q, new_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [ADDR_W-1:0]   scan_q, scan_d;
  logic [SLOT_W-1:0]   first_q, first_d;
  logic [SLOT_W-1:0]   last_q, last_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAPACITY-1:0] used_q, used_d;
  olist_status_e       status_q, status_d;
  logic                found_q, found_d;
  logic [VALUE_W-1:0]  data_q, data_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_found_q, out_found_d;
  logic [VALUE_W-1:0]  out_data_q, out_data_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;

  logic [SLOT_W-1:0]   lnk;
  logic                first_null;
  logic                prev_null;
  logic                lnk_null;
  logic                pos_bad;
  logic                at_pos;
  olist_mem_req_t      mreq;

  assign lnk        = lnk_rdata_i[SLOT_W-1:0];
  assign first_null = (first_q >= NULL_SLOT);
  assign prev_null  = (prev_q >= NULL_SLOT);
  assign lnk_null   = (lnk >= NULL_SLOT);
  assign pos_bad    = (pos_q == '0) || (CMP_W'(pos_q) > CMP_W'(count_q));
  assign at_pos     = (CMP_W'(k_q) == CMP_W'(pos_q));

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    val_d        = val_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    succ_d       = succ_q;
    new_d        = new_q;
    k_d          = k_q;
    scan_d       = scan_q;
    first_d      = first_q;
    last_d       = last_q;
    count_d      = count_q;
    used_d       = used_q;
    status_d     = status_q;
    found_d      = found_q;
    data_d       = data_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_data_d   = out_data_q;
    out_len_d    = out_len_q;
    mreq         = '0;
    mreq.rd_addr = SLOT_MAX_W'(cur_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = olist_func_e'(func_i);
          val_d   = value_i;
          pos_d   = pos_i;
          state_d = S_START;
        end
      end
      S_START: begin
        status_d     = STAT_OK;
        found_d      = 1'b0;
        data_d       = '0;
        cur_d        = first_q;
        prev_d       = NULL_SLOT;
        k_d          = CNT_W'(1);
        scan_d       = '0;
        mreq.rd_addr = SLOT_MAX_W'(first_q);
        state_d      = S_DONE;
        case (func_q)
          FN_APPEND, FN_PREPEND: begin
            if (count_q >= CAP_CNT) begin
              status_d = STAT_FULL;
            end else begin
              state_d = S_SCAN;
            end
          end
          FN_INSERT: begin
            if (pos_bad) begin
              status_d = STAT_BAD_POS;
            end else if (count_q >= CAP_CNT) begin
              status_d = STAT_FULL;
            end else begin
              state_d = S_WALK;
            end
          end
          FN_REMOVE, FN_FIND: begin
            if (first_null) begin
              status_d = STAT_NOT_FOUND;
            end else begin
              state_d = S_WALK;
            end
          end
          FN_READ: begin
            if (pos_bad) begin
              status_d = STAT_BAD_POS;
            end else begin
              state_d = S_WALK;
            end
          end
          FN_CLEAR: begin
            used_d  = '0;
            first_d = NULL_SLOT;
            last_d  = NULL_SLOT;
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if (func_q == FN_REMOVE || func_q == FN_FIND) begin
          if (val_rdata_i == val_q) begin
            found_d = 1'b1;
            succ_d  = lnk;
            state_d = (func_q == FN_FIND) ? S_DONE : S_UNLINK;
          end else if (lnk_null) begin
            status_d = STAT_NOT_FOUND;
            state_d  = S_DONE;
          end else begin
            prev_d       = cur_q;
            cur_d        = lnk;
            mreq.rd_addr = SLOT_MAX_W'(lnk);
          end
        end else begin
          if (at_pos) begin
            if (func_q == FN_READ) begin
              data_d  = val_rdata_i;
              state_d = S_DONE;
            end else begin
              succ_d  = lnk;
              state_d = S_SCAN;
            end
          end else begin
            cur_d        = lnk;
            k_d          = CNT_W'(k_q + 1'b1);
            mreq.rd_addr = SLOT_MAX_W'(lnk);
          end
        end
      end
      S_SCAN: begin
        if (!used_q[scan_q]) begin
          new_d   = SLOT_W'(scan_q);
          state_d = S_PLACE;
        end else begin
          scan_d = ADDR_W'(scan_q + 1'b1);
        end
      end
      S_PLACE: begin
        used_d[new_q[ADDR_W-1:0]] = 1'b1;
        mreq.val_we    = 1'b1;
        mreq.val_addr  = SLOT_MAX_W'(new_q);
        mreq.val_wdata = val_q;
        mreq.lnk_we    = 1'b1;
        mreq.lnk_addr  = SLOT_MAX_W'(new_q);
        if (func_q == FN_PREPEND && !first_null) begin
          mreq.lnk_wdata = SLOT_MAX_W'(first_q);
        end else if (func_q == FN_INSERT) begin
          mreq.lnk_wdata = SLOT_MAX_W'(succ_q);
        end else begin
          mreq.lnk_wdata = SLOT_MAX_W'(NULL_SLOT);
        end
        if (first_null) begin
          first_d = new_q;
          last_d  = new_q;
          count_d = CNT_W'(count_q + 1'b1);
          state_d = S_DONE;
        end else if (func_q == FN_PREPEND) begin
          first_d = new_q;
          count_d = CNT_W'(count_q + 1'b1);
          state_d = S_DONE;
        end else begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        mreq.lnk_we    = 1'b1;
        mreq.lnk_addr  = SLOT_MAX_W'((func_q == FN_APPEND) ? last_q : cur_q);
        mreq.lnk_wdata = SLOT_MAX_W'(new_q);
        if (func_q == FN_APPEND || cur_q == last_q) begin
          last_d = new_q;
        end
        count_d = CNT_W'(count_q + 1'b1);
        state_d = S_DONE;
      end
      S_UNLINK: begin
        if (prev_null) begin
          first_d = succ_q;
        end else begin
          mreq.lnk_we    = 1'b1;
          mreq.lnk_addr  = SLOT_MAX_W'(prev_q);
          mreq.lnk_wdata = SLOT_MAX_W'(succ_q);
        end
        if (cur_q == last_q) begin
          last_d = prev_q;
        end
        used_d[cur_q[ADDR_W-1:0]] = 1'b0;
        count_d = CNT_W'(count_q - 1'b1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_found_d  = found_q;
          out_data_d   = data_q;
          out_len_d    = LEN_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= NULL_SLOT;
      last_q      <= NULL_SLOT;
      count_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      count_q     <= count_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    succ_q       <= succ_d;
    new_q        <= new_d;
    k_q          <= k_d;
    scan_q       <= scan_d;
    status_q     <= status_d;
    found_q      <= found_d;
    data_q       <= data_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_data_q   <= out_data_d;
    out_len_q    <= out_len_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;
  assign data_o      = out_data_q;
  assign length_o    = out_len_q;
  assign mem_req_o   = mreq;

endmodule

### sv/olist_port_chk.sv
// Port checker of the ordered list engine and its bind to the top level
`timescale 1ns / 1ps
`include "ordered_list_engine_unit_defines.svh"

module olist_port_chk import olist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  `OLEU_ASSERT_NXT(a_one_item_at_a_time, clk_i, rst_ni, in_beat, !s_axis_tready)
  `OLEU_ASSERT_NXT(a_out_beat_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `OLEU_ASSERT_IMP(a_found_is_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == STAT_OK)
  `OLEU_ASSERT_IMP(a_data_only_on_read, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[31:0] != '0), (m_axis_tuser[1:0] == STAT_OK) && !m_axis_tuser[2])
  `OLEU_ASSERT_IMP(a_length_bounded, clk_i, rst_ni, m_axis_tvalid, 32'(m_axis_tdata[37:32]) <= CAPACITY)

endmodule

bind ordered_list_engine_unit olist_port_chk #(.CAPACITY(CAPACITY)) u_port_chk (.*);
